@@ rtl/crs_pkg.sv @@
package crs_pkg;

	localparam int T_FRAC_BITS_DEF = 16;
	localparam int COORD_WIDTH_DEF = 32;

	// register stages from input transaction to output register
	localparam int PIPE_DEPTH = 7;

	// headroom bits of the doubled basis weights above the fraction
	localparam int W_EXTRA_BITS = 4;

endpackage

@@ rtl/crs_basis.sv @@
module crs_basis #(
	parameter int T_FRAC_BITS = crs_pkg::T_FRAC_BITS_DEF,
	parameter int WW          = T_FRAC_BITS + crs_pkg::W_EXTRA_BITS
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [T_FRAC_BITS:0]        t_param,
	output logic signed [WW-1:0]        w_s3 [4]
);

	localparam int F  = T_FRAC_BITS;
	localparam int TW = T_FRAC_BITS + 1;

	localparam logic [TW-1:0]   ONE_T  = TW'(1) << F;
	localparam logic [2*TW-1:0] HALF_P = (2*TW)'(1) << (F - 1);
	localparam logic signed [WW-1:0] TWO_W = WW'(1) << (F + 1);

	logic [TW-1:0]   t_c;
	logic [2*TW-1:0] sq_rnd;
	logic [2*TW-1:0] cu_rnd;

	logic [TW-1:0] t_s1, t2_s1;
	logic [TW-1:0] t_s2, t2_s2, t3_s2;

	logic signed [WW-1:0] tx, t2x, t3x;

	assign t_c    = (t_param > ONE_T) ? ONE_T : t_param;
	assign sq_rnd = t_c * t_c + HALF_P;
	assign cu_rnd = t2_s1 * t_s1 + HALF_P;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t_c;
			t2_s1 <= sq_rnd[F+TW-1:F];
			t_s2  <= t_s1;
			t2_s2 <= t2_s1;
			t3_s2 <= cu_rnd[F+TW-1:F];
		end
	end

	assign tx  = $signed({{(WW-TW){1'b0}}, t_s2});
	assign t2x = $signed({{(WW-TW){1'b0}}, t2_s2});
	assign t3x = $signed({{(WW-TW){1'b0}}, t3_s2});

	// doubled Catmull-Rom weights, exact in Q.F
	always_ff @(posedge clk) begin
		if (en) begin
			w_s3[0] <= (t2x <<< 1) - t3x - tx;
			w_s3[1] <= t3x + (t3x <<< 1) - (t2x <<< 2) - t2x + TWO_W;
			w_s3[2] <= (t2x <<< 2) + tx - t3x - (t3x <<< 1);
			w_s3[3] <= t3x - t2x;
		end
	end

endmodule

@@ rtl/catmull_rom_spline_eval.sv @@
// Uniform Catmull-Rom segment evaluator, one axis per transaction.
// Input channel (in_valid/in_ready): t_param in unsigned Q1.T_FRAC_BITS,
// values above one are taken as one, and four control coordinates
// ctrl_p0..ctrl_p3 in signed Q16.16. Output channel (out_valid/out_ready):
// out_coord, the weighted sum rounded to nearest (ties up) and clamped to
// the coordinate range, with saturated set when clamping took place.
// A 3D point is sent as three transactions, x, y and z.
// Throughput: one transaction per clock while the receiver does not stall.
// The seven register stages from input acceptance to out_valid are: t squared,
// t cubed, basis weights, 4 parallel products, pair sums, final sum and
// rounding, clamp into the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops in the same cycle; nothing is lost or repeated.
// Bubbles are not squeezed out while stalled.
// Reset clears all valid bits; no state is kept between transactions.
module catmull_rom_spline_eval #(
	parameter int T_FRAC_BITS = crs_pkg::T_FRAC_BITS_DEF,
	parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [T_FRAC_BITS:0]          t_param,
	input  logic signed [COORD_WIDTH-1:0] ctrl_p0,
	input  logic signed [COORD_WIDTH-1:0] ctrl_p1,
	input  logic signed [COORD_WIDTH-1:0] ctrl_p2,
	input  logic signed [COORD_WIDTH-1:0] ctrl_p3,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] out_coord,
	output logic                          saturated
);

	localparam int F  = T_FRAC_BITS;
	localparam int CW = COORD_WIDTH;
	localparam int WW = F + crs_pkg::W_EXTRA_BITS;
	localparam int PW = CW + WW;
	localparam int SW = PW + 2;
	localparam int RW = SW - (F + 1);
	localparam int D  = crs_pkg::PIPE_DEPTH;

	localparam logic signed [SW-1:0] RND = SW'(1) << F;
	localparam logic signed [RW-1:0] MAXV = $signed({{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}});
	localparam logic signed [RW-1:0] MINV = $signed({{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}});

	logic         en;
	logic [D-1:0] vld_q;

	logic signed [CW-1:0] p_s1 [4];
	logic signed [CW-1:0] p_s2 [4];
	logic signed [CW-1:0] p_s3 [4];
	logic signed [WW-1:0] w_s3 [4];
	logic signed [PW-1:0] prod_s4 [4];
	logic signed [SW-1:0] sa_s5, sb_s5;
	logic signed [SW-1:0] acc;
	logic signed [RW-1:0] r_s6;

	assign en        = ~vld_q[D-1] | out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[D-1];
	assign acc       = sa_s5 + sb_s5 + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[D-2:0], in_valid};
		end
	end

	crs_basis #(
		.T_FRAC_BITS (T_FRAC_BITS),
		.WW          (WW)
	) u_basis (
		.clk     (clk),
		.en      (en),
		.t_param (t_param),
		.w_s3    (w_s3)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= ctrl_p0;
			p_s1[1] <= ctrl_p1;
			p_s1[2] <= ctrl_p2;
			p_s1[3] <= ctrl_p3;
			p_s2    <= p_s1;
			p_s3    <= p_s2;
			for (int i = 0; i < 4; i++) begin
				prod_s4[i] <= PW'(w_s3[i]) * PW'(p_s3[i]);
			end
			sa_s5 <= SW'(prod_s4[0]) + SW'(prod_s4[1]);
			sb_s5 <= SW'(prod_s4[2]) + SW'(prod_s4[3]);
			r_s6  <= acc[SW-1:F+1];
			if (r_s6 > MAXV) begin
				out_coord <= MAXV[CW-1:0];
				saturated <= 1'b1;
			end else if (r_s6 < MINV) begin
				out_coord <= MINV[CW-1:0];
				saturated <= 1'b1;
			end else begin
				out_coord <= r_s6[CW-1:0];
				saturated <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/crs_checker.sv @@
module crs_checker #(
	parameter int T_FRAC_BITS = crs_pkg::T_FRAC_BITS_DEF,
	parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [T_FRAC_BITS:0]          t_param,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] out_coord,
	input logic                          saturated
);

	localparam logic [COORD_WIDTH-1:0] MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// an offered input transaction carries a known t
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(t_param))
		else $error("input transaction offered with unknown t_param");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_coord) && $stable(saturated))
		else $error("output transaction changed while stalled");

	// clamped results sit on a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> out_coord == MAXC || out_coord == MINC)
		else $error("saturated result not at a limit");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline stalled");

endmodule

bind catmull_rom_spline_eval crs_checker #(
	.T_FRAC_BITS (T_FRAC_BITS),
	.COORD_WIDTH (COORD_WIDTH)
) u_crs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.t_param   (t_param),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_coord (out_coord),
	.saturated (saturated)
);

@@ tb/sv/catmull_rom_spline_eval_check.sv @@
module catmull_rom_spline_eval_check #(
	parameter int TF = crs_pkg::T_FRAC_BITS_DEF,
	parameter int CW = crs_pkg::COORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  logic [TF:0]   t_param,
	input  logic [CW-1:0] ctrl_p0,
	input  logic [CW-1:0] ctrl_p1,
	input  logic [CW-1:0] ctrl_p2,
	input  logic [CW-1:0] ctrl_p3,
	input  logic          out_valid,
	input  logic          out_ready,
	input  logic [CW-1:0] out_coord,
	input  logic          saturated,
	output int            fail_count,
	output int            pending,
	output int            result_count,
	output int            sat_count,
	output int            t_over_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};

	typedef struct packed {
		logic [CW-1:0] coord;
		logic          sat;
	} axis_result_t;

	axis_result_t expected_q[$];
	int errs;
	int n_results;
	int n_sat;
	int n_t_over;

	function automatic axis_result_t eval_segment(
		input logic [TF:0] traw,
		input logic signed [CW-1:0] p0,
		input logic signed [CW-1:0] p1,
		input logic signed [CW-1:0] p2,
		input logic signed [CW-1:0] p3
	);
		longint one;
		longint half;
		longint t;
		longint t2;
		longint t3;
		longint acc;
		longint r;
		longint maxv;
		longint minv;
		axis_result_t res;
		one = longint'(1) << TF;
		half = one >>> 1;
		t = (traw > T_ONE) ? one : longint'(traw);
		t2 = (t * t + half) >>> TF;
		t3 = (t2 * t + half) >>> TF;
		// doubled basis weights, exact in Q.TF
		acc = (-t3 + 2 * t2 - t) * longint'(p0)
			+ (3 * t3 - 5 * t2 + 2 * one) * longint'(p1)
			+ (-3 * t3 + 4 * t2 + t) * longint'(p2)
			+ (t3 - t2) * longint'(p3);
		r = (acc + one) >>> (TF + 1);
		maxv = (longint'(1) << (CW - 1)) - 1;
		minv = -maxv - 1;
		res.sat = 1'b0;
		if (r > maxv) begin
			r = maxv;
			res.sat = 1'b1;
		end else if (r < minv) begin
			r = minv;
			res.sat = 1'b1;
		end
		res.coord = r[CW-1:0];
		return res;
	endfunction

	always @(posedge clk) begin
		axis_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: unexpected result out_coord %0d saturated %b",
							$time, $signed(out_coord), saturated);
				end else begin
					want = expected_q.pop_front();
					n_results++;
					if (want.sat)
						n_sat++;
					if (out_coord !== want.coord || saturated !== want.sat) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch out_coord %0d exp %0d, saturated %b exp %b",
								$time, $signed(out_coord), $signed(want.coord),
								saturated, want.sat);
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_q.push_back(eval_segment(t_param, ctrl_p0, ctrl_p1, ctrl_p2, ctrl_p3));
				if (t_param > T_ONE)
					n_t_over++;
			end
		end
		fail_count <= errs;
		pending <= expected_q.size();
		result_count <= n_results;
		sat_count <= n_sat;
		t_over_count <= n_t_over;
	end

endmodule

@@ tb/sv/catmull_rom_spline_eval_test.sv @@
module catmull_rom_spline_eval_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TF = crs_pkg::T_FRAC_BITS_DEF;
	localparam int CW = crs_pkg::COORD_WIDTH_DEF;
	localparam int POINTS = 534;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 4000;

	localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};
	localparam logic [TF:0] T_HALF = {2'b01, {(TF-1){1'b0}}};
	localparam logic [TF:0] T_MAX = {(TF+1){1'b1}};
	localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] C_ZERO = '0;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [TF:0]   t_param;
	logic [CW-1:0] ctrl_p0;
	logic [CW-1:0] ctrl_p1;
	logic [CW-1:0] ctrl_p2;
	logic [CW-1:0] ctrl_p3;
	logic          out_valid;
	logic          out_ready;
	logic [CW-1:0] out_coord;
	logic          saturated;

	int fail_count;
	int pending;
	int result_count;
	int sat_count;
	int t_over_count;
	int idle_cycles;
	int holds_done;
	bit no_idle;
	bit hold_req;

	catmull_rom_spline_eval #(
		.T_FRAC_BITS(TF),
		.COORD_WIDTH(CW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.t_param(t_param),
		.ctrl_p0(ctrl_p0),
		.ctrl_p1(ctrl_p1),
		.ctrl_p2(ctrl_p2),
		.ctrl_p3(ctrl_p3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_coord(out_coord),
		.saturated(saturated)
	);

	catmull_rom_spline_eval_check #(
		.TF(TF),
		.CW(CW)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.t_param(t_param),
		.ctrl_p0(ctrl_p0),
		.ctrl_p1(ctrl_p1),
		.ctrl_p2(ctrl_p2),
		.ctrl_p3(ctrl_p3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_coord(out_coord),
		.saturated(saturated),
		.fail_count(fail_count),
		.pending(pending),
		.result_count(result_count),
		.sat_count(sat_count),
		.t_over_count(t_over_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d results outstanding", idle_cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 27);
			end
		end
	end

	task automatic send_axis(
		input logic [TF:0]   t,
		input logic [CW-1:0] p0,
		input logic [CW-1:0] p1,
		input logic [CW-1:0] p2,
		input logic [CW-1:0] p3
	);
		while (!no_idle && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		t_param <= t;
		ctrl_p0 <= p0;
		ctrl_p1 <= p1;
		ctrl_p2 <= p2;
		ctrl_p3 <= p3;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		int sel;
		logic [31:0] r;
		sel = $urandom_range(99);
		r = $urandom;
		if (sel < 55)
			return CW'($signed(r[20:0]));
		else if (sel < 80)
			return CW'(r);
		else if (sel < 90)
			return $urandom_range(1) ? C_MAX - CW'(r[7:0]) : C_MIN + CW'(r[7:0]);
		else
			return CW'($signed(r[29:0]));
	endfunction

	function automatic logic [TF:0] rand_t();
		int sel;
		sel = $urandom_range(99);
		if (sel < 4)
			return '0;
		else if (sel < 8)
			return T_ONE;
		else if (sel < 18)
			return (TF+1)'($urandom_range(int'(T_MAX), int'(T_ONE) + 1));
		else
			return (TF+1)'($urandom_range(int'(T_ONE), 0));
	endfunction

	initial begin
		logic [TF:0] t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		t_param = '0;
		ctrl_p0 = '0;
		ctrl_p1 = '0;
		ctrl_p2 = '0;
		ctrl_p3 = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// endpoints, t above one, extremes, overshoot in both directions
		send_axis('0, rand_coord(), 32'sh0001_8000, rand_coord(), rand_coord());
		send_axis(T_ONE, rand_coord(), rand_coord(), 32'shFFFE_4000, rand_coord());
		send_axis(T_MAX, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		send_axis(T_ONE + 1'b1, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		send_axis({1'b1, {(TF/2){2'b10}}}, C_ZERO, C_MAX, C_MIN, C_ZERO);
		send_axis(T_HALF, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
		send_axis(T_HALF, C_MAX, C_MAX, C_MAX, C_MAX);
		send_axis(T_HALF, C_MIN, C_MIN, C_MIN, C_MIN);
		send_axis(T_HALF, C_MIN, C_MAX, C_MAX, C_MIN);
		send_axis(T_HALF, C_MAX, C_MIN, C_MIN, C_MAX);
		send_axis((TF+1)'(1), C_MAX, C_MIN, C_MAX, C_MIN);
		send_axis(T_ONE - 1'b1, C_MIN, C_MAX, C_MIN, C_MAX);
		send_axis(T_HALF >> 1, C_MIN, C_MAX, C_MAX, C_MIN);
		send_axis(T_HALF + (T_HALF >> 1), C_MAX, C_MIN, C_MIN, C_MAX);
		send_axis({1'b0, {(TF/2){2'b10}}}, {(CW/2){2'b10}}, {(CW/2){2'b01}},
			{(CW/2){2'b10}}, {(CW/2){2'b01}});
		send_axis({1'b0, {(TF/2){2'b01}}}, {(CW/2){2'b01}}, {(CW/2){2'b10}},
			{(CW/2){2'b01}}, {(CW/2){2'b10}});
		send_axis(T_HALF, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0001, 32'shFFFF_FFFF);
		send_axis('0, C_MAX, C_MIN, C_MAX, C_MAX);
		send_axis(T_ONE, C_MIN, C_MAX, C_MAX, C_MIN);

		// random points, three axes sharing one t
		for (int i = 0; i < POINTS; i++) begin
			if (i == POINTS / 4)
				no_idle = 1'b1;
			if (i == POINTS / 2) begin
				no_idle = 1'b0;
				hold_req = 1'b1;
			end
			t = rand_t();
			for (int axis = 0; axis < 3; axis++)
				send_axis(t, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (crs_pkg::PIPE_DEPTH + 4) @(posedge clk);

		$display("Covered %0d segment evaluations (%0d with t above one, %0d clamped),",
			result_count, t_over_count, sat_count);
		$display("idle and stall gaps on both sides, and %0d receiver hold-off(s) of %0d cycles.",
			holds_done, HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/crs_pkg.sv
rtl/crs_basis.sv
rtl/catmull_rom_spline_eval.sv
rtl/crs_checker.sv
tb/sv/catmull_rom_spline_eval_check.sv
tb/sv/catmull_rom_spline_eval_test.sv
